// ===== design/xpnu_pkg.sv =====
package xpnu_pkg;

    // Widths of the byte stream and of the decoded fields.
    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 9;
    localparam int MASK_W   = 5;
    localparam int CHAN_W   = 5;
    localparam int COUNT_W  = 6;
    localparam int ROW_W    = 16;

    // Default width of the internal row counter.
    localparam int XPNU_ROW_BITS = 16;

    // Reset value of the channel count register.
    localparam logic [COUNT_W-1:0] CHAN_COUNT_RESET = 6'd4;

    // Stream constants of the packed pattern format.
    localparam logic [BYTE_W-1:0]  LEAD_MASK_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0]  NOTE_OFF_BYTE  = 8'd97;
    localparam logic [BYTE_W-1:0]  VOL_WIN_LO     = 8'h10;
    localparam logic [BYTE_W-1:0]  VOL_WIN_HI     = 8'h50;
    localparam logic [FIELD_W-1:0] VOL_DEFAULT    = 9'h03F;
    localparam logic [FIELD_W-1:0] FX_SET_VOLUME  = 9'h00C;
    localparam logic [FIELD_W-1:0] FX_CLEARED     = 9'h0FF;
    localparam logic [BYTE_W-1:0]  FX_UNSUPPORTED = 8'hFF;
    localparam logic [FIELD_W-1:0] FIELD_NONE     = 9'h1FF;
    localparam logic [MASK_W-1:0]  MASK_FULL_NOTE = 5'h1E;
    localparam logic [MASK_W-1:0]  FLAGS_KEEP_SV  = 5'h07;

    // Bit positions in the pending mask and in the presence flags.
    localparam int BIT_NOTE  = 0;
    localparam int BIT_INSTR = 1;
    localparam int BIT_VOL   = 2;
    localparam int BIT_FX    = 3;
    localparam int BIT_PARAM = 4;

    // One decoded note.
    typedef struct packed {
        logic signed [FIELD_W-1:0] note_value;
        logic signed [FIELD_W-1:0] instrument_number;
        logic signed [FIELD_W-1:0] volume_value;
        logic        [BYTE_W-1:0]  effect_code;
        logic signed [FIELD_W-1:0] effect_param;
        logic        [MASK_W-1:0]  present_flags;
        logic        [CHAN_W-1:0]  channel_index;
        logic        [ROW_W-1:0]   row_index;
    } t_note_result;

endpackage

// ===== design/xm_pattern_note_unpacker.sv =====
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: data_byte[7:0]; tuser: pattern_start[0]
// m_axis    out        tdata: note, instrument, volume, effect, param, channel, row
//                      tuser: present_flags[4:0]
// cfg       in         i_cfg_data: channel_count[5:0]
//
// One byte is accepted every cycle while the result side keeps up. A byte is decoded
// while it sits in the input register, and a finished note is then registered into
// the output register. Reset is synchronous and active low; it clears the decode
// state, sets the channel count to four and empties both registers. When the output
// register holds an untaken note the input register keeps any byte it holds, and the
// input side stalls once that register is full.
module xm_pattern_note_unpacker
    import xpnu_pkg::*;
#(
    parameter int ROW_BITS = XPNU_ROW_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // data_byte[7:0]
    input  logic [0:0]          s_axis_tuser,   // pattern_start[0]

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // note_value[8:0], instrument_number[17:9], volume_value[26:18],
    // effect_code[34:27], effect_param[43:35], channel_index[48:44],
    // row_index[64:49], zero fill[71:65]
    output logic [71:0]         m_axis_tdata,
    output logic [4:0]          m_axis_tuser,   // present_flags[4:0]

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data
);

    // Input register.
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_start;

    // Output register.
    logic               r_out_valid;
    t_note_result       r_out;

    logic               out_free;
    logic               step;
    logic               dec_done;
    t_note_result       dec_result;

    // The held byte is decoded once the output register can take whatever it yields.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;
    assign o_cfg_ready   = 1'b1;

    xpnu_decode #(
        .ROW_BITS   (ROW_BITS)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .i_start    (r_in_start),
        .o_done     (dec_done),
        .o_result   (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end

            if (step && dec_done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
        end
        if (step && dec_done) begin
            r_out <= dec_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.present_flags;
    assign m_axis_tdata  = {7'd0,
                            r_out.row_index,
                            r_out.channel_index,
                            r_out.effect_param,
                            r_out.effect_code,
                            r_out.volume_value,
                            r_out.instrument_number,
                            r_out.note_value};

endmodule

// ===== design/xpnu_decode.sv =====
module xpnu_decode
    import xpnu_pkg::*;
#(
    parameter int ROW_BITS = XPNU_ROW_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_data,
    input  logic                i_step,
    input  logic [BYTE_W-1:0]   i_byte,
    input  logic                i_start,
    output logic                o_done,
    output t_note_result        o_result
);

    logic [COUNT_W-1:0]         r_chan_count;
    logic [MASK_W-1:0]          r_mask;
    logic signed [FIELD_W-1:0]  r_note;
    logic signed [FIELD_W-1:0]  r_instr;
    logic signed [FIELD_W-1:0]  r_vol;
    logic signed [FIELD_W-1:0]  r_fx;
    logic signed [FIELD_W-1:0]  r_param;
    logic [MASK_W-1:0]          r_flags;
    logic [CHAN_W-1:0]          r_chan;
    logic [ROW_BITS-1:0]        r_row;

    logic [MASK_W-1:0]          n_mask;
    logic signed [FIELD_W-1:0]  n_note;
    logic signed [FIELD_W-1:0]  n_instr;
    logic signed [FIELD_W-1:0]  n_vol;
    logic signed [FIELD_W-1:0]  n_fx;
    logic signed [FIELD_W-1:0]  n_param;
    logic [MASK_W-1:0]          n_flags;
    logic [CHAN_W-1:0]          n_chan;
    logic [ROW_BITS-1:0]        n_row;

    logic [MASK_W-1:0]          mask_eff;
    logic [CHAN_W-1:0]          chan_eff;
    logic [COUNT_W-1:0]         chan_next;
    logic                       chan_wrap;
    logic                       done;

    // Note byte to note value: note-off maps to zero, any other byte maps to itself minus one.
    function automatic logic signed [FIELD_W-1:0] note_from_byte(input logic [BYTE_W-1:0] b);
        logic [FIELD_W-1:0] v;
        if (b == NOTE_OFF_BYTE) begin
            v = '0;
        end else begin
            v = {1'b0, b} - FIELD_W'(1);
        end
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] map_effect(input logic signed [FIELD_W-1:0] e);
        logic [BYTE_W-1:0] code;
        code = FX_UNSUPPORTED;
        if (!e[FIELD_W-1]) begin
            case (e[BYTE_W-1:0]) inside
                8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                8'h08, 8'h0A, 8'h0B, 8'h0D, 8'h0F: code = e[BYTE_W-1:0];
                default: code = FX_UNSUPPORTED;
            endcase
        end
        return code;
    endfunction

    always_comb begin
        // A pattern start drops any partial note and restarts the channel.
        mask_eff = i_start ? '0 : r_mask;
        chan_eff = i_start ? '0 : r_chan;

        n_mask  = mask_eff;
        n_note  = r_note;
        n_instr = r_instr;
        n_vol   = r_vol;
        n_fx    = r_fx;
        n_param = r_param;
        n_flags = r_flags;

        if (mask_eff == '0) begin
            // Lead byte of a note.
            n_vol = VOL_DEFAULT;
            if (i_byte < LEAD_MASK_MIN) begin
                n_note  = note_from_byte(i_byte);
                n_flags = MASK_W'(1) << BIT_NOTE;
                n_mask  = MASK_FULL_NOTE;
            end else begin
                n_flags = '0;
                n_mask  = i_byte[MASK_W-1:0];
            end
        end else if (mask_eff[BIT_NOTE]) begin
            n_mask[BIT_NOTE]  = 1'b0;
            n_note            = note_from_byte(i_byte);
            n_flags[BIT_NOTE] = 1'b1;
        end else if (mask_eff[BIT_INSTR]) begin
            n_mask[BIT_INSTR]  = 1'b0;
            n_instr            = {1'b0, i_byte};
            n_flags[BIT_INSTR] = 1'b1;
        end else if (mask_eff[BIT_VOL]) begin
            n_mask[BIT_VOL] = 1'b0;
            if (i_byte >= VOL_WIN_LO && i_byte <= VOL_WIN_HI) begin
                n_vol            = {1'b0, i_byte - VOL_WIN_LO};
                n_flags[BIT_VOL] = 1'b1;
            end else begin
                n_vol = {1'b0, i_byte};
            end
        end else if (mask_eff[BIT_FX]) begin
            n_mask[BIT_FX]  = 1'b0;
            n_fx            = {1'b0, i_byte};
            n_flags[BIT_FX] = 1'b1;
        end else begin
            n_mask[BIT_PARAM]  = 1'b0;
            n_param            = {1'b0, i_byte};
            n_flags[BIT_PARAM] = 1'b1;
        end

        done = (n_mask == '0);

        // Set-volume effect turns into a volume and is consumed.
        if (done && n_fx == FX_SET_VOLUME) begin
            n_vol   = n_param;
            n_flags = (n_flags | (MASK_W'(1) << BIT_VOL)) & FLAGS_KEEP_SV;
            n_fx    = FX_CLEARED;
        end

        // A count of zero acts as one; the counter never passes channel 31.
        chan_next = {1'b0, chan_eff} + COUNT_W'(1);
        chan_wrap = (chan_next >= r_chan_count) || chan_next[COUNT_W-1];

        n_chan = chan_eff;
        n_row  = r_row;
        if (done) begin
            if (chan_wrap) begin
                n_chan = '0;
                n_row  = r_row + ROW_BITS'(1);
            end else begin
                n_chan = chan_next[CHAN_W-1:0];
            end
        end

        o_done                     = done;
        o_result.note_value        = n_note;
        o_result.instrument_number = n_instr;
        o_result.volume_value      = n_vol;
        o_result.effect_code       = map_effect(n_fx);
        o_result.effect_param      = n_param;
        o_result.present_flags     = n_flags;
        o_result.channel_index     = chan_eff;
        o_result.row_index         = ROW_W'(r_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_count <= CHAN_COUNT_RESET;
            r_mask       <= '0;
            r_note       <= FIELD_NONE;
            r_instr      <= FIELD_NONE;
            r_vol        <= FIELD_NONE;
            r_fx         <= FIELD_NONE;
            r_param      <= FIELD_NONE;
            r_flags      <= '0;
            r_chan       <= '0;
            r_row        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_chan_count <= i_cfg_data;
            end
            if (i_step) begin
                r_mask  <= n_mask;
                r_note  <= n_note;
                r_instr <= n_instr;
                r_vol   <= n_vol;
                r_fx    <= n_fx;
                r_param <= n_param;
                r_flags <= n_flags;
                r_chan  <= n_chan;
                r_row   <= n_row;
            end
        end
    end

endmodule
